FILE: design/occ_pkg.sv
// Shared types and constants for the debounced occupancy counter.
// Used by every module of the block; depends on nothing.

package occ_pkg;

  localparam int unsigned DIST_WIDTH   = 12;
  localparam int unsigned RUN_WIDTH    = 4;
  localparam int unsigned OCC_WIDTH    = 16;
  localparam int unsigned CFG_WIDTH    = 12;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [DIST_WIDTH-1:0] THRESHOLD_RESET = 12'd150;
  localparam logic [RUN_WIDTH-1:0]  STABLE_RESET    = 4'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_STABLE    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic entry_fell;
    logic exit_fell;
  } fall_t;

endpackage

FILE: design/occ_sensor.sv
// Debounce filter for one distance sensor: occupied flag and run counter.
// Depends on occ_pkg for the run counter width.

module occ_sensor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           present,
  input  logic [occ_pkg::RUN_WIDTH-1:0]  stable,
  output logic                           fell
);

  logic                          flag;
  logic                          flag_next;
  logic [occ_pkg::RUN_WIDTH-1:0] run;
  logic [occ_pkg::RUN_WIDTH-1:0] run_next;
  logic [occ_pkg::RUN_WIDTH-1:0] run_inc;
  logic                          flips;

  always_comb begin
    run_inc   = run + 1'b1;
    flips     = (present != flag) && (run_inc >= stable);
    flag_next = flag;
    run_next  = '0;
    if (present != flag) begin
      if (flips) begin
        flag_next = present;
      end else begin
        run_next = run_inc;
      end
    end
  end

  assign fell = advance && flips && flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      run  <= '0;
    end else if (advance) begin
      flag <= flag_next;
      run  <= run_next;
    end
  end

endmodule

FILE: design/occ_total.sv
// Saturating vehicle total: entrance falls add one, exit falls remove one.
// Depends on occ_pkg for the fall event struct.

module occ_total #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  occ_pkg::fall_t         falls,
  output logic [COUNT_WIDTH-1:0] count_next
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] after_entry;

  always_comb begin
    after_entry = total;
    if (falls.entry_fell && (total != COUNT_MAX)) begin
      after_entry = total + 1'b1;
    end
    count_next = after_entry;
    if (falls.exit_fell && (after_entry != '0)) begin
      count_next = after_entry - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (advance) begin
      total <= count_next;
    end
  end

endmodule

FILE: design/debounced_occupancy_counter.sv
// Top level of the debounced occupancy counter: input and result registers,
// configuration registers, two sensor filters and the vehicle total.
// Depends on occ_pkg, occ_sensor and occ_total.
//
// Usage: each input beat on in_valid/in_stall carries one entrance and one
// exit distance sample. Each beat yields exactly one result beat on
// out_valid/out_stall carrying the vehicle count after that sample pair.
// A beat is captured in the input register; when it advances, the filters
// and the total update and the count lands in the result register, where
// it is offered on out_valid. Throughput is one beat per cycle while the
// receiver does not stall: the input register moves into the result
// register whenever the result register is empty or being taken.
// When the receiver stalls, the result holds, the input register keeps one
// more beat, and only then is in_stall raised.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// edge; index 0 is the distance threshold, index 1 the stable sample count,
// other indexes are ignored. Write them only while no beat is in flight.
// Synchronous reset empties both registers, clears both sensor flags, run
// counters and the total, and restores threshold 150 and stable count 2.

module debounced_occupancy_counter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [occ_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [occ_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [occ_pkg::DIST_WIDTH-1:0]    entrance_distance,
  input  logic [occ_pkg::DIST_WIDTH-1:0]    exit_distance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [occ_pkg::OCC_WIDTH-1:0]     occupancy
);

  logic [occ_pkg::DIST_WIDTH-1:0] threshold;
  logic [occ_pkg::RUN_WIDTH-1:0]  stable;

  logic                           s1_valid;
  logic [occ_pkg::DIST_WIDTH-1:0] s1_entrance;
  logic [occ_pkg::DIST_WIDTH-1:0] s1_exit;

  logic                   load;
  logic                   advance;
  occ_pkg::fall_t         falls;
  logic [COUNT_WIDTH-1:0] count_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= occ_pkg::THRESHOLD_RESET;
      stable    <= occ_pkg::STABLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        occ_pkg::REG_THRESHOLD: threshold <= cfg_data[occ_pkg::DIST_WIDTH-1:0];
        occ_pkg::REG_STABLE:    stable    <= cfg_data[occ_pkg::RUN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_entrance <= entrance_distance;
      s1_exit     <= exit_distance;
    end
  end

  occ_sensor u_entry (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .present (s1_entrance < threshold),
    .stable  (stable),
    .fell    (falls.entry_fell)
  );

  occ_sensor u_exit (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .present (s1_exit < threshold),
    .stable  (stable),
    .fell    (falls.exit_fell)
  );

  occ_total #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_total (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .falls      (falls),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      occupancy <= occ_pkg::OCC_WIDTH'(count_next);
    end
  end

endmodule

FILE: design/occ_checker.sv
// Port-level checker for the debounced occupancy counter, bound to the top.
// Depends on occ_pkg for port widths.

module occ_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [occ_pkg::OCC_WIDTH-1:0]     occupancy
);

  logic                          in_acc;
  logic                          out_acc;
  logic [1:0]                    pending;
  logic                          have_last;
  logic [occ_pkg::OCC_WIDTH-1:0] last_occ;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      have_last <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        have_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      last_occ <= occupancy;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(occupancy))
    else $error("Stalled result changed or was dropped.");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("Result offered with no input beat outstanding.");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd3) && (!in_stall || (pending == 2'd2)))
    else $error("Beats in flight exceed the two registers.");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_last |->
      (occupancy == last_occ) ||
      (occupancy == occ_pkg::OCC_WIDTH'(last_occ + 1'b1)) ||
      (occ_pkg::OCC_WIDTH'(occupancy + 1'b1) == last_occ))
    else $error("Count moved by more than one between results.");

endmodule

bind debounced_occupancy_counter occ_checker u_occ_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .occupancy         (occupancy)
);

FILE: bench/tb.sv
// Self-checking bench for the debounced occupancy counter: directed samples, several
// register settings with random vehicle passes, and exits against an empty count.
// Depends on occ_pkg and debounced_occupancy_counter.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned SENSOR_ENTRY = 0;
  localparam int unsigned SENSOR_EXIT  = 1;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_PAIRS  = 225;
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam logic [occ_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [occ_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [occ_pkg::DIST_WIDTH-1:0] entrance;
    logic [occ_pkg::DIST_WIDTH-1:0] leaving;
    logic                           typed;
    logic [occ_pkg::OCC_WIDTH-1:0]  occ;
  } probe_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [occ_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [occ_pkg::CFG_WIDTH-1:0]    cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [occ_pkg::DIST_WIDTH-1:0]   entrance_distance = '0;
  logic [occ_pkg::DIST_WIDTH-1:0]   exit_distance = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [occ_pkg::OCC_WIDTH-1:0]    occupancy;

  logic [occ_pkg::DIST_WIDTH-1:0]   threshold_mirror = occ_pkg::THRESHOLD_RESET;
  logic [occ_pkg::RUN_WIDTH-1:0]    stable_mirror = occ_pkg::STABLE_RESET;
  logic                             sensor_flag [2] = '{1'b0, 1'b0};
  logic [occ_pkg::RUN_WIDTH-1:0]    sensor_run [2] = '{'0, '0};
  logic [COUNT_WIDTH-1:0]           vehicle_total = '0;

  logic [occ_pkg::OCC_WIDTH-1:0]    pending_occupancy [$];
  probe_t                           directed_rows [DIRECTED_ROWS];
  logic                             no_idle = 1'b0;
  logic                             hold_request = 1'b0;
  int unsigned                      mismatches = 0;
  int unsigned                      pairs_sent = 0;
  int unsigned                      idle_cycles = 0;

  debounced_occupancy_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .entrance_distance(entrance_distance),
    .exit_distance(exit_distance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .occupancy(occupancy)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic sensor_falls(input int unsigned s, input logic present);
    logic fell;
    fell = 1'b0;
    if (present != sensor_flag[s]) begin
      sensor_run[s] = sensor_run[s] + 1'b1;
      if (sensor_run[s] >= stable_mirror) begin
        fell = sensor_flag[s];
        sensor_flag[s] = present;
        sensor_run[s] = '0;
      end
    end else begin
      sensor_run[s] = '0;
    end
    return fell;
  endfunction

  // The entrance is settled before the exit, so a double fall at zero ends at zero.
  function automatic logic [occ_pkg::OCC_WIDTH-1:0] occupancy_after(
      input logic [occ_pkg::DIST_WIDTH-1:0] ent,
      input logic [occ_pkg::DIST_WIDTH-1:0] ext);
    logic entry_fell;
    logic exit_fell;
    entry_fell = sensor_falls(SENSOR_ENTRY, ent < threshold_mirror);
    exit_fell = sensor_falls(SENSOR_EXIT, ext < threshold_mirror);
    if (entry_fell && vehicle_total != '1) begin
      vehicle_total = vehicle_total + 1'b1;
    end
    if (exit_fell && vehicle_total != '0) begin
      vehicle_total = vehicle_total - 1'b1;
    end
    return occ_pkg::OCC_WIDTH'(vehicle_total);
  endfunction

  function automatic logic [occ_pkg::DIST_WIDTH-1:0] pick_distance(input logic present);
    if (threshold_mirror == '0) begin
      return occ_pkg::DIST_WIDTH'($urandom_range(0, 4095));
    end
    if (present) begin
      return occ_pkg::DIST_WIDTH'($urandom_range(0, threshold_mirror - 1));
    end
    return occ_pkg::DIST_WIDTH'($urandom_range(threshold_mirror, 4095));
  endfunction

  task automatic offer_pair(input logic [occ_pkg::DIST_WIDTH-1:0] ent,
                            input logic [occ_pkg::DIST_WIDTH-1:0] ext,
                            input logic typed,
                            input logic [occ_pkg::OCC_WIDTH-1:0] typed_occ);
    int unsigned gap;
    logic [occ_pkg::OCC_WIDTH-1:0] predicted;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    entrance_distance <= ent;
    exit_distance <= ext;
    do @(posedge clk); while (in_stall);
    predicted = occupancy_after(ent, ext);
    pending_occupancy.push_back(typed ? typed_occ : predicted);
    pairs_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_occupancy.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [occ_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [occ_pkg::CFG_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      occ_pkg::REG_THRESHOLD: threshold_mirror = data;
      occ_pkg::REG_STABLE: stable_mirror = data[occ_pkg::RUN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold on request, and the compare.
  initial begin
    int unsigned hold;
    logic [occ_pkg::OCC_WIDTH-1:0] want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      hold = no_idle ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_occupancy.size() == 0) begin
        $display("%0t: occupancy beat %0d arrived with nothing expected", $time, occupancy);
        mismatches++;
      end else begin
        want = pending_occupancy.pop_front();
        if (occupancy !== want) begin
          $display("%0t: occupancy mismatch, expected %0d, got %0d", $time, want, occupancy);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_occupancy.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned thr_plan [PHASES];
    int unsigned stable_plan [PHASES];
    logic [occ_pkg::DIST_WIDTH-1:0] distance_pick [2];
    logic want_present [2];
    int unsigned dwell_left [2];
    logic [occ_pkg::DIST_WIDTH-1:0] reading;

    directed_rows = '{
      '{12'd4095, 12'd4095, 1'b1, 16'd0},
      '{12'd0,    12'd4095, 1'b1, 16'd0},
      '{12'd0,    12'd4095, 1'b1, 16'd0},
      '{12'd149,  12'd4095, 1'b1, 16'd0},
      '{12'd150,  12'd4095, 1'b1, 16'd0},
      '{12'd150,  12'd4095, 1'b1, 16'd1},
      '{12'd4095, 12'd0,    1'b0, 16'd0},
      '{12'd4095, 12'd0,    1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b1, 16'd0},
      '{12'd4095, 12'd0,    1'b0, 16'd0},
      '{12'd4095, 12'd0,    1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b1, 16'd0},
      '{12'd0,    12'd0,    1'b0, 16'd0},
      '{12'd0,    12'd0,    1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b1, 16'd0},
      '{12'd0,    12'd4095, 1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b0, 16'd0},
      '{12'd0,    12'd4095, 1'b0, 16'd0},
      '{12'd4095, 12'd4095, 1'b1, 16'd0},
      '{12'd2048, 12'd2730, 1'b0, 16'd0},
      '{12'd1365, 12'd3276, 1'b0, 16'd0}
    };
    thr_plan = '{150, 0, 4095, 1000, 2048, 300, 0, 0};
    stable_plan = '{2, 3, 1, 0, 15, 5, 0, 0};
    want_present = '{1'b0, 1'b0};
    dwell_left = '{0, 0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      offer_pair(directed_rows[r].entrance, directed_rows[r].leaving,
                 directed_rows[r].typed, directed_rows[r].occ);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      if (p >= 6) begin
        thr_plan[p] = $urandom_range(1, 4095);
        stable_plan[p] = $urandom_range(0, 15);
      end
      write_reg(occ_pkg::REG_THRESHOLD, occ_pkg::CFG_WIDTH'(thr_plan[p]));
      write_reg(occ_pkg::REG_STABLE,
                (occ_pkg::CFG_WIDTH'($urandom) << occ_pkg::RUN_WIDTH)
                | occ_pkg::CFG_WIDTH'(stable_plan[p]));
      write_reg(REG_SPARE_A, occ_pkg::CFG_WIDTH'($urandom));
      write_reg(REG_SPARE_B, occ_pkg::CFG_WIDTH'($urandom));
      if (p == 1) begin
        no_idle = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) begin
          offer_pair(pick_distance(i[2]), pick_distance(i[3]), 1'b0, '0);
        end
      end
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        if (i % 40 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        for (int s = 0; s < 2; s++) begin
          if (dwell_left[s] == 0) begin
            want_present[s] = !want_present[s];
            dwell_left[s] = $urandom_range(1, stable_mirror + (s == SENSOR_EXIT ? 6 : 4));
          end
          dwell_left[s]--;
          reading = pick_distance(want_present[s] ^ ($urandom_range(0, 11) == 0));
          if ($urandom_range(0, 9) == 0) begin
            reading = occ_pkg::DIST_WIDTH'($urandom);
          end
          distance_pick[s] = reading;
        end
        offer_pair(distance_pick[0], distance_pick[1], 1'b0, '0);
      end
    end

    // Exit passes alone walk the total down; it saturates at zero.
    drain_and_settle();
    write_reg(occ_pkg::REG_THRESHOLD, 12'd4095);
    write_reg(occ_pkg::REG_STABLE, 12'd1);
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) begin
      offer_pair(12'd4095, i[0] ? 12'd4095 : 12'd0, 1'b0, '0);
    end

    drain_and_settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d sample pairs over %0d register settings with random stalls,", pairs_sent,
             PHASES + 1);
    $display("a long result hold, and exit passes against an empty vehicle count.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
